### src/cpft_pkg.sv
// ----------------------------------------------------------------------------
// cpft_pkg
// Shared widths and types for the common prime factor test block.
// ----------------------------------------------------------------------------
package cpft_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FACTOR_WIDTH = 32;
    localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [SHIFT_WIDTH-1:0] t_shift;

endpackage

### src/common_prime_factor_test_core.sv
// ----------------------------------------------------------------------------
// common_prime_factor_test_core
// Decides whether a streamed set of factors shares no common prime.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one factor per item, tagged with
// its side (i_on_left) and an end-of-set mark (i_last). Output channel
// (o_valid / i_ready) carries one result per set: o_primitive_res and
// o_missing_side.
// A factor of 0 or 1, or the first factor of at least 2 in a set, is taken
// directly, without the gcd. Any other factor is folded into the running
// divisor by a binary gcd: one shared subtract/compare/shift step per cycle.
// o_ready is low while the gcd sequencer runs or a finish step waits. On
// the last item of a set the result is loaded into the output register from
// the finish step, after any fold ends, and the set state clears.
// The output register parts the two sides: items that are not last keep
// being taken while a result waits; a last item holds in a finish step until
// the previous result is taken. A synchronous active-low reset clears the
// set state, the sequencer and o_valid.
// ----------------------------------------------------------------------------
module common_prime_factor_test_core
    import cpft_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [FACTOR_WIDTH-1:0] i_factor,
    input  logic                    i_on_left,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_primitive_res,
    output logic                    o_missing_side
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_value r_divisor;
    t_value r_a;
    t_value r_b;
    t_shift r_k;
    logic   r_last;
    logic   r_saw_small;
    logic   r_saw_left;
    logic   r_saw_right;
    logic   r_valid;
    logic   r_prim;
    logic   r_missing;

    t_value w_f;
    logic   w_accept;
    logic   w_small;
    logic   w_missing;
    logic   w_prim;
    logic   w_load;

    assign w_f       = i_factor[VALUE_WIDTH-1:0];
    assign w_accept  = i_valid && (r_state == ST_IDLE);
    assign w_small   = (w_f[VALUE_WIDTH-1:1] == '0);
    assign w_missing = !(r_saw_left && r_saw_right);
    assign w_prim    = !w_missing && (r_saw_small || (r_divisor == t_value'(1)));
    assign w_load    = (r_state == ST_FINISH) && (!r_valid || i_ready);

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_valid;
    assign o_primitive_res = r_prim;
    assign o_missing_side  = r_missing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_divisor   <= '0;
            r_saw_small <= 1'b0;
            r_saw_left  <= 1'b0;
            r_saw_right <= 1'b0;
            r_valid     <= 1'b0;
            r_last      <= 1'b0;
            r_k         <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_on_left) begin
                            r_saw_left <= 1'b1;
                        end else begin
                            r_saw_right <= 1'b1;
                        end
                        r_last <= i_last;
                        priority if (w_small) begin
                            r_saw_small <= 1'b1;
                            if (i_last) r_state <= ST_FINISH;
                        end else if (r_divisor == '0) begin
                            r_divisor <= w_f;
                            if (i_last) r_state <= ST_FINISH;
                        end else begin
                            r_a     <= r_divisor;
                            r_b     <= w_f;
                            r_k     <= '0;
                            r_state <= ST_GCD;
                        end
                    end
                end
                ST_GCD: begin
                    priority if (r_a == r_b) begin
                        if (r_k == '0) begin
                            r_divisor <= r_a;
                            r_state   <= r_last ? ST_FINISH : ST_IDLE;
                        end else begin
                            r_a <= r_a << 1;
                            r_b <= r_b << 1;
                            r_k <= r_k - t_shift'(1);
                        end
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + t_shift'(1);
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a > r_b) begin
                        r_a <= r_a - r_b;
                    end else begin
                        r_b <= r_b - r_a;
                    end
                end
                ST_FINISH: begin
                    if (w_load) begin
                        r_prim      <= w_prim;
                        r_missing   <= w_missing;
                        r_divisor   <= '0;
                        r_saw_small <= 1'b0;
                        r_saw_left  <= 1'b0;
                        r_saw_right <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD) |-> (r_a != '0) && (r_b != '0))
        else $error("gcd operand reached zero");

    a_missing_not_prim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_missing) |-> !r_prim)
        else $error("missing side reported as primitive");

    a_last_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_state != ST_IDLE))
        else $error("last item did not start a result");

    a_gcd_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_GCD) && (r_a == r_b) && (r_k == '0)) |=>
        (r_divisor == $past(r_a)))
        else $error("gcd result not committed");

endmodule
